@@ hdl/cbz_pkg.sv @@
package cbz_pkg;

    localparam int COORD_W  = 24;
    localparam int WEIGHT_W = 18;
    localparam int FRAC_W   = 16;
    localparam int INDEX_W  = 8;
    localparam int PROD_W   = COORD_W + WEIGHT_W;
    localparam int ACC_W    = PROD_W + 2;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t ctrl_a_x;
        coord_t ctrl_a_y;
        coord_t ctrl_b_x;
        coord_t ctrl_b_y;
        coord_t end_x;
        coord_t end_y;
    } curve_t;

    typedef struct packed {
        coord_t               sample_x;
        coord_t               sample_y;
        logic [INDEX_W-1:0]   sample_index;
        logic                 last_sample;
    } sample_t;

    typedef struct packed {
        weight_t w0;
        weight_t w1;
        weight_t w2;
        weight_t w3;
    } weight_set_t;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic               last;
    } step_t;

endpackage

@@ hdl/cbz_seq.sv @@
module cbz_seq #(
    parameter int POINTS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output cbz_pkg::weight_set_t weights,
    output cbz_pkg::step_t      step
);

    localparam int IDXW = (POINTS > 2) ? $clog2(POINTS) : 1;
    localparam longint unsigned N = longint'(POINTS - 1);
    localparam longint unsigned DEN = N * N * N;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(POINTS - 1);

    cbz_pkg::weight_t w0_tab [POINTS];
    cbz_pkg::weight_t w1_tab [POINTS];
    cbz_pkg::weight_t w2_tab [POINTS];
    cbz_pkg::weight_t w3_tab [POINTS];

    for (genvar g = 0; g < POINTS; g++)
    begin : g_weight
        localparam longint unsigned GI = longint'(g);
        localparam longint unsigned M = N - GI;
        localparam longint unsigned W1 = (3 * GI * M * M * 65536 + DEN / 2) / DEN;
        localparam longint unsigned W2 = (3 * GI * GI * M * 65536 + DEN / 2) / DEN;
        localparam longint unsigned W3 = (GI * GI * GI * 65536 + DEN / 2) / DEN;
        localparam longint W0 = longint'(65536) - longint'(W1) - longint'(W2)
                                - longint'(W3);
        assign w0_tab[g] = cbz_pkg::weight_t'(W0);
        assign w1_tab[g] = cbz_pkg::weight_t'(W1);
        assign w2_tab[g] = cbz_pkg::weight_t'(W2);
        assign w3_tab[g] = cbz_pkg::weight_t'(W3);
    end

    logic            active_reg, active_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic            at_last;
    logic            accept;

    assign at_last = (idx_reg == LAST_IDX);
    assign busy    = active_reg && !at_last;
    assign accept  = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        priority if (accept)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            if (at_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    assign weights.w0 = w0_tab[idx_reg];
    assign weights.w1 = w1_tab[idx_reg];
    assign weights.w2 = w2_tab[idx_reg];
    assign weights.w3 = w3_tab[idx_reg];

    assign step.valid = active_reg;
    assign step.index = cbz_pkg::INDEX_W'(idx_reg);
    assign step.last  = at_last;

endmodule

@@ hdl/cbz_lane.sv @@
module cbz_lane (
    input  logic                 clk,
    input  cbz_pkg::weight_set_t weights,
    input  cbz_pkg::coord_t      p0,
    input  cbz_pkg::coord_t      p1,
    input  cbz_pkg::coord_t      p2,
    input  cbz_pkg::coord_t      p3,
    output cbz_pkg::coord_t      result
);

    localparam int SH_W = cbz_pkg::ACC_W - cbz_pkg::FRAC_W;
    localparam logic signed [SH_W-1:0] MAX_V = SH_W'(8388607);
    localparam logic signed [SH_W-1:0] MIN_V = -SH_W'(8388608);
    localparam logic signed [cbz_pkg::ACC_W-1:0] HALF =
        cbz_pkg::ACC_W'(1) <<< (cbz_pkg::FRAC_W - 1);

    cbz_pkg::prod_t prod0_reg, prod1_reg, prod2_reg, prod3_reg;
    cbz_pkg::coord_t result_reg, result_next;

    logic signed [cbz_pkg::ACC_W-1:0] acc;
    logic signed [SH_W-1:0]           shifted;

    always_ff @(posedge clk)
    begin
        prod0_reg  <= weights.w0 * p0;
        prod1_reg  <= weights.w1 * p1;
        prod2_reg  <= weights.w2 * p2;
        prod3_reg  <= weights.w3 * p3;
        result_reg <= result_next;
    end

    always_comb
    begin
        acc = {{2{prod0_reg[cbz_pkg::PROD_W-1]}}, prod0_reg}
            + {{2{prod1_reg[cbz_pkg::PROD_W-1]}}, prod1_reg}
            + {{2{prod2_reg[cbz_pkg::PROD_W-1]}}, prod2_reg}
            + {{2{prod3_reg[cbz_pkg::PROD_W-1]}}, prod3_reg}
            + HALF;
        shifted = acc[cbz_pkg::ACC_W-1:cbz_pkg::FRAC_W];
        priority if (shifted > MAX_V)
        begin
            result_next = cbz_pkg::coord_t'(MAX_V);
        end
        else if (shifted < MIN_V)
        begin
            result_next = cbz_pkg::coord_t'(MIN_V);
        end
        else
        begin
            result_next = shifted[cbz_pkg::COORD_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

@@ hdl/cubic_bezier_sampler.sv @@
// Cubic Bezier curve sampler.
// Input: raise start with the four control points on curve (Q16.8 x/y pairs).
// The transaction is taken at a rising edge where start is high and busy low.
// Output: POINTS samples at t = i/(POINTS-1), i = 0 .. POINTS-1, one per
// cycle, each shown for exactly one cycle with strobe high. sample carries
// x, y (Q16.8, rounded to nearest), the index i and a last_sample flag on
// the final point.
// Path: each sample is registered as products, then as the rounded lane result,
// with its step in s1_reg then s2_reg; the rest follow on consecutive cycles.
// Curves: while one runs, the next is taken only once the index counter, which
// steps once a cycle through the weight table, reaches its last index; busy
// drops during the last index so the next curve starts without a gap.
// x and y are computed in two lanes of four multipliers each, with products
// registered before the rounding sum.
// Reset clears the sequencer and the output strobe; no samples are pending
// afterward. The receiver cannot stall: every sample must be taken when shown.
module cubic_bezier_sampler #(
    parameter int POINTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cbz_pkg::curve_t  curve,
    output logic             strobe,
    output cbz_pkg::sample_t sample
);

    cbz_pkg::curve_t      curve_reg;
    cbz_pkg::weight_set_t weights;
    cbz_pkg::step_t       step;
    cbz_pkg::step_t       s1_reg, s2_reg;
    cbz_pkg::coord_t      lane_x, lane_y;

    cbz_seq #(
        .POINTS (POINTS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .weights (weights),
        .step    (step)
    );

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            curve_reg <= curve;
        end
    end

    cbz_lane u_lane_x (
        .clk     (clk),
        .weights (weights),
        .p0      (curve_reg.start_x),
        .p1      (curve_reg.ctrl_a_x),
        .p2      (curve_reg.ctrl_b_x),
        .p3      (curve_reg.end_x),
        .result  (lane_x)
    );

    cbz_lane u_lane_y (
        .clk     (clk),
        .weights (weights),
        .p0      (curve_reg.start_y),
        .p1      (curve_reg.ctrl_a_y),
        .p2      (curve_reg.ctrl_b_y),
        .p3      (curve_reg.end_y),
        .result  (lane_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= step;
            s2_reg <= s1_reg;
        end
    end

    assign strobe              = s2_reg.valid;
    assign sample.sample_x     = lane_x;
    assign sample.sample_y     = lane_y;
    assign sample.sample_index = s2_reg.index;
    assign sample.last_sample  = s2_reg.last;

endmodule
